// ----- design/bdc_pkg.sv -----
package bdc_pkg;

    localparam int COORD_BITS  = 24;
    localparam int FRAC_BITS_T = 16;
    localparam int T_BITS      = FRAC_BITS_T + 1;
    localparam int DIFF_BITS   = COORD_BITS + 1;
    localparam int PROD_BITS   = DIFF_BITS + T_BITS;
    localparam int SUM_BITS    = PROD_BITS - FRAC_BITS_T;

    // slave tdata: param_t, ctrl_value_0..3, padded to whole bytes
    localparam int S_FIELD_BITS = T_BITS + 4 * COORD_BITS;
    localparam int S_DATA_BITS  = ((S_FIELD_BITS + 7) / 8) * 8;
    localparam int M_DATA_BITS  = ((COORD_BITS + 7) / 8) * 8;

    // pipeline depth: three levels of difference, product, round-and-add
    localparam int NUM_STAGES = 9;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic        [T_BITS-1:0]     param_t_t;
    typedef logic signed [DIFF_BITS-1:0]  diff_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [SUM_BITS-1:0]   sum_t;

    localparam param_t_t T_ONE  = param_t_t'(1) << FRAC_BITS_T;
    localparam prod_t    T_HALF = prod_t'(1) << (FRAC_BITS_T - 1);

    function automatic diff_t coord_diff(coord_t a, coord_t b);
        return diff_t'(b) - diff_t'(a);
    endfunction

    function automatic prod_t diff_scale(diff_t d, param_t_t t);
        return prod_t'(d) * prod_t'($signed({1'b0, t}));
    endfunction

    // a + round_half_up(p / 2^FRAC_BITS_T); the exact result lies between the
    // two lerp operands, so keeping the low COORD_BITS bits is lossless
    function automatic coord_t lerp_finish(coord_t a, prod_t p);
        prod_t rounded;
        sum_t  sum;
        rounded = p + T_HALF;
        sum     = $signed(rounded[PROD_BITS-1:FRAC_BITS_T]) + sum_t'(a);
        return sum[COORD_BITS-1:0];
    endfunction

endpackage

// ----- design/bezier_de_casteljau_eval.sv -----
// Bezier coordinate evaluator, de Casteljau repeated linear interpolation.
//
// Slave stream (s_*): one transaction carries t and the four control values
// of one axis; a 3D point takes three transactions. Master stream (m_*): one
// transaction per input transaction, in the same order, carrying the curve
// coordinate at t. Config channel (cfg_*): one bit, 1 = cubic (four points),
// 0 = quadratic (three points, ctrl_value_3 ignored); always ready, write it
// only while the pipeline is empty. Reset value is cubic.
//
// Throughput is one transaction per cycle while the receiver takes results:
// each of the three interpolation levels takes three stages (difference,
// 25x17 multiply, round and add), and every stage has its own valid bit and
// load enable.
//
// Reset clears all stage valid bits and sets cubic mode. When the receiver
// stalls, the result holds in the output register and the stages behind it
// keep filling empty slots, so s_tready stays high until every stage holds
// a transaction; nothing is dropped or duplicated.
module bezier_de_casteljau_eval (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic                           cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [16:0] param_t, [40:17] ctrl_value_0, [64:41] ctrl_value_1,
    // [88:65] ctrl_value_2, [112:89] ctrl_value_3, rest zero
    input  logic [bdc_pkg::S_DATA_BITS-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [23:0] curve_value
    output logic [bdc_pkg::M_DATA_BITS-1:0] m_tdata
);
    import bdc_pkg::*;

    // configuration
    logic cubic_reg;

    // stage handshake
    logic [NUM_STAGES:1] valid_reg;
    logic [NUM_STAGES:1] load_en;

    // input field extraction
    param_t_t t_in;
    param_t_t t_clamp_next;
    coord_t   pnt_in [4];

    // level 1: p0..p3 -> a, b, c
    param_t_t s1_t_reg, s2_t_reg, s3_t_reg, s4_t_reg, s5_t_reg, s6_t_reg;
    logic     s1_cubic_reg, s2_cubic_reg, s3_cubic_reg, s4_cubic_reg;
    logic     s5_cubic_reg, s6_cubic_reg;
    coord_t   s1_base_reg [3];
    diff_t    s1_diff_reg [3];
    coord_t   s2_base_reg [3];
    prod_t    s2_prod_reg [3];
    coord_t   s3_lerp_reg [3];
    coord_t   lvl1_lerp_next [3];

    // level 2: a, b, c -> ab, bc
    coord_t   s4_base_reg [2];
    diff_t    s4_diff_reg [2];
    coord_t   s5_base_reg [2];
    prod_t    s5_prod_reg [2];
    coord_t   s6_lerp_reg [2];
    coord_t   lvl2_lerp_next [2];

    // level 3: ab, bc -> result (quadratic items pass ab through)
    param_t_t s7_t_reg;
    logic     s7_cubic_reg;
    coord_t   s7_base_reg;
    diff_t    s7_diff_reg;
    coord_t   s8_base_reg;
    prod_t    s8_prod_reg;
    coord_t   s9_result_reg;
    diff_t    lvl3_diff_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cubic_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            cubic_reg <= cfg_data;
        end
    end

    // A stage loads when it is empty or its content moves on this cycle.
    always_comb begin
        load_en[NUM_STAGES] = !valid_reg[NUM_STAGES] || m_tready;
        for (int k = NUM_STAGES - 1; k >= 1; k--) begin
            load_en[k] = !valid_reg[k] || load_en[k+1];
        end
    end

    assign s_tready = load_en[1];
    assign m_tvalid = valid_reg[NUM_STAGES];
    assign m_tdata  = M_DATA_BITS'($unsigned(s9_result_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (load_en[1]) begin
                valid_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NUM_STAGES; k++) begin
                if (load_en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // unpack and saturate t to 1.0
    always_comb begin
        t_in = s_tdata[T_BITS-1:0];
        for (int i = 0; i < 4; i++) begin
            pnt_in[i] = s_tdata[T_BITS + i*COORD_BITS +: COORD_BITS];
        end
        t_clamp_next = (t_in > T_ONE) ? T_ONE : t_in;
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            lvl1_lerp_next[i] = lerp_finish(s2_base_reg[i], s2_prod_reg[i]);
        end
        for (int i = 0; i < 2; i++) begin
            lvl2_lerp_next[i] = lerp_finish(s5_base_reg[i], s5_prod_reg[i]);
        end
        // quadratic: interpolate ab with itself, which returns ab exactly
        lvl3_diff_next = s6_cubic_reg ? coord_diff(s6_lerp_reg[0], s6_lerp_reg[1]) : '0;
    end

    // level 1
    always_ff @(posedge aclk) begin
        if (load_en[1]) begin
            s1_t_reg     <= t_clamp_next;
            s1_cubic_reg <= cubic_reg;
            for (int i = 0; i < 3; i++) begin
                s1_base_reg[i] <= pnt_in[i];
                s1_diff_reg[i] <= coord_diff(pnt_in[i], pnt_in[i+1]);
            end
        end
        if (load_en[2]) begin
            s2_t_reg     <= s1_t_reg;
            s2_cubic_reg <= s1_cubic_reg;
            for (int i = 0; i < 3; i++) begin
                s2_base_reg[i] <= s1_base_reg[i];
                s2_prod_reg[i] <= diff_scale(s1_diff_reg[i], s1_t_reg);
            end
        end
        if (load_en[3]) begin
            s3_t_reg     <= s2_t_reg;
            s3_cubic_reg <= s2_cubic_reg;
            for (int i = 0; i < 3; i++) begin
                s3_lerp_reg[i] <= lvl1_lerp_next[i];
            end
        end
    end

    // level 2
    always_ff @(posedge aclk) begin
        if (load_en[4]) begin
            s4_t_reg     <= s3_t_reg;
            s4_cubic_reg <= s3_cubic_reg;
            for (int i = 0; i < 2; i++) begin
                s4_base_reg[i] <= s3_lerp_reg[i];
                s4_diff_reg[i] <= coord_diff(s3_lerp_reg[i], s3_lerp_reg[i+1]);
            end
        end
        if (load_en[5]) begin
            s5_t_reg     <= s4_t_reg;
            s5_cubic_reg <= s4_cubic_reg;
            for (int i = 0; i < 2; i++) begin
                s5_base_reg[i] <= s4_base_reg[i];
                s5_prod_reg[i] <= diff_scale(s4_diff_reg[i], s4_t_reg);
            end
        end
        if (load_en[6]) begin
            s6_t_reg     <= s5_t_reg;
            s6_cubic_reg <= s5_cubic_reg;
            for (int i = 0; i < 2; i++) begin
                s6_lerp_reg[i] <= lvl2_lerp_next[i];
            end
        end
    end

    // level 3
    always_ff @(posedge aclk) begin
        if (load_en[7]) begin
            s7_t_reg     <= s6_t_reg;
            s7_cubic_reg <= s6_cubic_reg;
            s7_base_reg  <= s6_lerp_reg[0];
            s7_diff_reg  <= lvl3_diff_next;
        end
        if (load_en[8]) begin
            s8_base_reg <= s7_base_reg;
            s8_prod_reg <= diff_scale(s7_diff_reg, s7_t_reg);
        end
        if (load_en[9]) begin
            s9_result_reg <= lerp_finish(s8_base_reg, s8_prod_reg);
        end
    end

`ifndef SYNTHESIS
    // an empty first stage always takes a transaction
    a_empty_head_ready : assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg[1] |-> s_tready)
        else $error("s_tready low while the first stage is empty");

    // saturation keeps t within 1.0
    a_t_saturated : assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[1] |-> (s1_t_reg <= T_ONE))
        else $error("t above 1.0 entered the pipeline");

    // quadratic items carry a zero difference into the last level
    a_quad_passthru : assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[7] && !s7_cubic_reg) |-> (s7_diff_reg == '0))
        else $error("quadratic transaction with nonzero last-level difference");

    // a stalled middle stage keeps its transaction
    a_stall_keeps : assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg[5] && !load_en[5]) |=> valid_reg[5])
        else $error("stalled stage lost its transaction");
`endif

endmodule

// ----- tb/bezier_de_casteljau_eval_test.sv -----
module bezier_de_casteljau_eval_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bdc_pkg::*;

    // One axis of one curve sample, as it travels on the slave stream.
    typedef struct {
        param_t_t t;
        coord_t   c0;
        coord_t   c1;
        coord_t   c2;
        coord_t   c3;
    } axis_sample_t;

    localparam coord_t   COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam coord_t   COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam param_t_t T_ALL_ONES = '1;
    localparam int       RANDOM_PER_PHASE = 125;
    localparam int       HOLD_OFF_CYCLES = 80;
    localparam int       DRAIN_LIMIT = 4000;

    // Expected curve values in stream order, plus the running degree setting.
    class curve_scoreboard;
        bit     cubic_mode;
        coord_t curve_q[$];
        int     errors;
        int     compared;
        int     n_cubic;
        int     n_quadratic;
        int     n_saturated;

        function new();
            cubic_mode = 1'b1;
        endfunction

        function void set_degree(bit cubic);
            cubic_mode = cubic;
        endfunction

        function int pending();
            return curve_q.size();
        endfunction

        // a + (b - a) * t, rounded half up on the exact product
        function longint lerp_q(longint a, longint b, longint t);
            longint prod;
            prod = (b - a) * t;
            return a + ((prod + (longint'(1) << (FRAC_BITS_T - 1))) >>> FRAC_BITS_T);
        endfunction

        function coord_t eval_curve(axis_sample_t it);
            longint t;
            longint p0, p1, p2, p3, a, b, c, ab, bc, r;
            t  = (it.t > T_ONE) ? longint'(T_ONE) : longint'(it.t);
            p0 = longint'(it.c0);
            p1 = longint'(it.c1);
            p2 = longint'(it.c2);
            p3 = longint'(it.c3);
            a  = lerp_q(p0, p1, t);
            b  = lerp_q(p1, p2, t);
            if (cubic_mode) begin
                c  = lerp_q(p2, p3, t);
                ab = lerp_q(a, b, t);
                bc = lerp_q(b, c, t);
                r  = lerp_q(ab, bc, t);
            end else begin
                r  = lerp_q(a, b, t);
            end
            return coord_t'(r);
        endfunction

        function void note_input(axis_sample_t it);
            curve_q.insert(curve_q.size(), eval_curve(it));
            if (cubic_mode) n_cubic++;
            else n_quadratic++;
            if (it.t > T_ONE) n_saturated++;
        endfunction

        function void check_result(logic [M_DATA_BITS-1:0] data);
            coord_t got;
            coord_t want;
            got = coord_t'(data[COORD_BITS-1:0]);
            if (curve_q.size() == 0) begin
                $error("curve_value: no result expected, got %0d", got);
                errors++;
                return;
            end
            want = curve_q.pop_front();
            compared++;
            if (got !== want) begin
                $error("curve_value: expected %0d, got %0d", want, got);
                errors++;
            end
        endfunction

        function void finish();
            if (curve_q.size() != 0) begin
                $error("curve_value: %0d results never arrived", curve_q.size());
                errors++;
            end
        endfunction
    endclass

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic                   cfg_data = 1'b1;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    // [16:0] param_t, [40:17] ctrl_value_0, [64:41] ctrl_value_1,
    // [88:65] ctrl_value_2, [112:89] ctrl_value_3, rest zero
    logic [S_DATA_BITS-1:0] s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    // [23:0] curve_value
    logic [M_DATA_BITS-1:0] m_tdata;

    curve_scoreboard sb = new();

    // Idle-pattern control: eager flags give stretches with no idling,
    // burst forces back-to-back input for the pressure phase.
    bit tx_eager = 1'b0;
    bit rx_eager = 1'b0;
    bit tx_burst = 1'b0;
    bit hold_off_request = 1'b0;
    int hold_offs_done = 0;

    bezier_de_casteljau_eval u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Hard stop: far beyond the slowest legal run (524 transactions, each
    // with the longest input gap and receiver stall, plus the hold-off).
    initial begin
        #2_000_000;
        $display("bezier_de_casteljau_eval_test: errors");
        $finish;
    end

    function automatic int tx_wait();
        if ($urandom_range(0, 29) == 0) tx_eager = !tx_eager;
        if (tx_eager || tx_burst) return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic int rx_wait();
        if ($urandom_range(0, 29) == 0) rx_eager = !rx_eager;
        if (rx_eager) return 0;
        return $urandom_range(0, 12);
    endfunction

    function automatic axis_sample_t make_sample(param_t_t t, coord_t c0, coord_t c1,
                                                 coord_t c2, coord_t c3);
        axis_sample_t it;
        it.t  = t;
        it.c0 = c0;
        it.c1 = c1;
        it.c2 = c2;
        it.c3 = c3;
        return it;
    endfunction

    function automatic coord_t random_coord();
        case ($urandom_range(0, 9))
            0:       return COORD_MAX;
            1:       return COORD_MIN;
            2:       return coord_t'(int'($urandom_range(0, 8191)) - 4096);
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic param_t_t random_param();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return T_ONE;
            2:       return param_t_t'($urandom_range(int'(T_ONE) + 1, int'(T_ALL_ONES)));
            3:       return param_t_t'($urandom);
            default: return param_t_t'($urandom_range(0, int'(T_ONE)));
        endcase
    endfunction

    // Offer one sample after a random gap; note it once it is taken.
    // Leave s_tvalid high afterwards so a zero gap keeps the stream dense.
    task automatic send_sample(axis_sample_t it);
        int gap;
        gap = tx_wait();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_BITS'({it.c3, it.c2, it.c1, it.c0, it.t});
        do @(posedge aclk); while (!s_tready);
        sb.note_input(it);
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        while (sb.pending() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge aclk);
            guard++;
        end
    endtask

    // Empties the pipeline first: close the input stream, drain,
    // then write the degree register.
    task automatic write_degree(bit cubic);
        s_tvalid <= 1'b0;
        wait_drained();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= cubic;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.set_degree(cubic);
    endtask

    // Extremes of t and of the control values, t above one (saturates),
    // rounding ties on both signs, a flat curve, and a fourth control value
    // that only matters in cubic mode.
    task automatic send_directed();
        send_sample(make_sample('0,         COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        send_sample(make_sample(T_ONE,      COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        send_sample(make_sample(T_ONE >> 1, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MAX));
        send_sample(make_sample(param_t_t'(1), COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN));
        send_sample(make_sample(param_t_t'(T_ONE - 1), COORD_MAX, COORD_MIN, COORD_MAX,
                                COORD_MIN));
        send_sample(make_sample(param_t_t'(T_ONE + 1), coord_t'(0), coord_t'(100),
                                coord_t'(200), coord_t'(300)));
        send_sample(make_sample(T_ALL_ONES, COORD_MIN, coord_t'(0), COORD_MAX, coord_t'(5)));
        send_sample(make_sample(T_ONE >> 1, coord_t'(0), coord_t'(1), coord_t'(0),
                                coord_t'(0)));
        send_sample(make_sample(T_ONE >> 1, coord_t'(0), coord_t'(-1), coord_t'(0),
                                coord_t'(0)));
        send_sample(make_sample(T_ONE >> 1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX));
        send_sample(make_sample(param_t_t'(12345), coord_t'(4096), coord_t'(-4096),
                                coord_t'(8192), COORD_MIN));
        send_sample(make_sample(T_ONE >> 2, coord_t'(-1), coord_t'(-1), coord_t'(-1),
                                coord_t'(-1)));
    endtask

    task automatic send_random(int count);
        for (int i = 0; i < count; i++) begin
            send_sample(make_sample(random_param(), random_coord(), random_coord(),
                                    random_coord(), random_coord()));
        end
    endtask

    // Result side: stall at random, take each result and check it. When a
    // hold-off is requested, keep m_tready low long enough for the pipeline
    // to fill and push back on s_tready.
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_wait();
            if (hold_off_request) begin
                stall = HOLD_OFF_CYCLES;
                hold_off_request = 1'b0;
                hold_offs_done++;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    initial begin
        int guard;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed samples in both degrees.
        write_degree(1'b0);
        send_directed();
        write_degree(1'b1);
        send_directed();

        // Random phases, alternating degree. The second one runs the input
        // back to back while the receiver holds off.
        write_degree(1'b0);
        send_random(RANDOM_PER_PHASE);

        write_degree(1'b1);
        tx_burst = 1'b1;
        hold_off_request = 1'b1;
        send_random(RANDOM_PER_PHASE);
        tx_burst = 1'b0;

        write_degree(1'b0);
        send_random(RANDOM_PER_PHASE);
        write_degree(1'b1);
        send_random(RANDOM_PER_PHASE);

        // Close the stream, collect what is still in flight, and give any
        // stray result the pipeline depth plus margin to show up.
        s_tvalid <= 1'b0;
        wait_drained();
        guard = 0;
        while (guard < NUM_STAGES + 20) begin
            @(posedge aclk);
            guard++;
        end
        sb.finish();

        $display("covered %0d cubic and %0d quadratic transactions, %0d with t above one",
                 sb.n_cubic, sb.n_quadratic, sb.n_saturated);
        $display("compared %0d curve values across %0d receiver hold-offs",
                 sb.compared, hold_offs_done);
        if (sb.errors == 0) begin
            $display("bezier_de_casteljau_eval_test: clean");
        end else begin
            $display("bezier_de_casteljau_eval_test: errors");
        end
        $finish;
    end

endmodule
